>>> src/utf8dp_pkg.sv
// Package for the UTF-8 decimal integer parser: types, constants and the digit range table.
package utf8dp_pkg;

    localparam int VALUE_OUT_W = 32;

    localparam logic [7:0] CHAR_MINUS   = 8'h2d;
    localparam logic [7:0] CHAR_PLUS    = 8'h2b;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [3:0] DIGIT_RADIX  = 4'd10;

    // Character lengths as stored: byte count minus one
    localparam logic [1:0] LEN_TWO   = 2'd1;
    localparam logic [1:0] LEN_THREE = 2'd2;
    localparam logic [1:0] LEN_FOUR  = 2'd3;

    typedef struct packed {
        logic [1:0]  len_m1;
        logic [23:0] prefix;
        logic [7:0]  lo;
        logic [7:0]  hi;
    } digit_range_t;

    typedef struct packed {
        logic       hit;
        logic [3:0] digit;
    } digit_hit_t;

    localparam int RANGE_COUNT = 54;

    localparam digit_range_t DIGIT_RANGES [RANGE_COUNT] = '{
        '{LEN_TWO, 24'h0000d9, 8'ha0, 8'ha9}, '{LEN_TWO, 24'h0000db, 8'hb0, 8'hb9},
        '{LEN_TWO, 24'h0000df, 8'h80, 8'h89},
        '{LEN_THREE, 24'h00e0a5, 8'ha6, 8'haf}, '{LEN_THREE, 24'h00e0a7, 8'ha6, 8'haf},
        '{LEN_THREE, 24'h00e0a9, 8'ha6, 8'haf}, '{LEN_THREE, 24'h00e0ab, 8'ha6, 8'haf},
        '{LEN_THREE, 24'h00e0ad, 8'ha6, 8'haf}, '{LEN_THREE, 24'h00e0af, 8'ha6, 8'haf},
        '{LEN_THREE, 24'h00e0b1, 8'ha6, 8'haf}, '{LEN_THREE, 24'h00e0b3, 8'ha6, 8'haf},
        '{LEN_THREE, 24'h00e0b5, 8'ha6, 8'haf}, '{LEN_THREE, 24'h00e0b7, 8'ha6, 8'haf},
        '{LEN_THREE, 24'h00e0b9, 8'h90, 8'h99}, '{LEN_THREE, 24'h00e0bb, 8'h90, 8'h99},
        '{LEN_THREE, 24'h00e0bc, 8'ha0, 8'ha9},
        '{LEN_THREE, 24'h00e181, 8'h80, 8'h89}, '{LEN_THREE, 24'h00e182, 8'h90, 8'h99},
        '{LEN_THREE, 24'h00e19f, 8'ha0, 8'ha9}, '{LEN_THREE, 24'h00e1a0, 8'h90, 8'h99},
        '{LEN_THREE, 24'h00e1a5, 8'h86, 8'h8f}, '{LEN_THREE, 24'h00e1a7, 8'h90, 8'h99},
        '{LEN_THREE, 24'h00e1aa, 8'h80, 8'h89}, '{LEN_THREE, 24'h00e1aa, 8'h90, 8'h99},
        '{LEN_THREE, 24'h00e1ad, 8'h90, 8'h99}, '{LEN_THREE, 24'h00e1ae, 8'hb0, 8'hb9},
        '{LEN_THREE, 24'h00e1b1, 8'h80, 8'h89}, '{LEN_THREE, 24'h00e1b1, 8'h90, 8'h99},
        '{LEN_THREE, 24'h00ea98, 8'ha0, 8'ha9}, '{LEN_THREE, 24'h00eaa3, 8'h90, 8'h99},
        '{LEN_THREE, 24'h00eaa4, 8'h80, 8'h89}, '{LEN_THREE, 24'h00eaa7, 8'h90, 8'h99},
        '{LEN_THREE, 24'h00eaa7, 8'hb0, 8'hb9}, '{LEN_THREE, 24'h00eaa9, 8'h90, 8'h99},
        '{LEN_THREE, 24'h00eaaf, 8'hb0, 8'hb9},
        '{LEN_THREE, 24'h00efbc, 8'h90, 8'h99},
        '{LEN_FOUR, 24'hf09092, 8'ha0, 8'ha9}, '{LEN_FOUR, 24'hf09181, 8'ha6, 8'haf},
        '{LEN_FOUR, 24'hf09183, 8'hb0, 8'hb9}, '{LEN_FOUR, 24'hf09184, 8'hb6, 8'hbf},
        '{LEN_FOUR, 24'hf09187, 8'h90, 8'h99}, '{LEN_FOUR, 24'hf0918b, 8'hb0, 8'hb9},
        '{LEN_FOUR, 24'hf09191, 8'h90, 8'h99}, '{LEN_FOUR, 24'hf09193, 8'h90, 8'h99},
        '{LEN_FOUR, 24'hf09199, 8'h90, 8'h99}, '{LEN_FOUR, 24'hf0919b, 8'h80, 8'h89},
        '{LEN_FOUR, 24'hf0919c, 8'hb0, 8'hb9}, '{LEN_FOUR, 24'hf091a3, 8'ha0, 8'ha9},
        '{LEN_FOUR, 24'hf091b1, 8'h90, 8'h99}, '{LEN_FOUR, 24'hf091b5, 8'h90, 8'h99},
        '{LEN_FOUR, 24'hf096a9, 8'ha0, 8'ha9}, '{LEN_FOUR, 24'hf096ad, 8'h90, 8'h99},
        '{LEN_FOUR, 24'hf09d9f, 8'h8e, 8'hbf}, '{LEN_FOUR, 24'hf09ea5, 8'h90, 8'h99}
    };

    // Byte count of a digit character from its lead byte, 0 when no digit starts here
    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        len = 3'd0;
        if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
            len = 3'd1;
        end else if (b == 8'hd9 || b == 8'hdb || b == 8'hdf) begin
            len = 3'd2;
        end else if (b == 8'he0 || b == 8'he1 || b == 8'hea || b == 8'hef) begin
            len = 3'd3;
        end else if (b == 8'hf0) begin
            len = 3'd4;
        end
        return len;
    endfunction

    // Offset into a range, folded to 0..9; offsets stay below 50
    function automatic logic [3:0] fold_digit(input logic [7:0] off);
        logic [7:0] v;
        v = off;
        if (v >= 8'd40) begin
            v = v - 8'd40;
        end else if (v >= 8'd30) begin
            v = v - 8'd30;
        end else if (v >= 8'd20) begin
            v = v - 8'd20;
        end else if (v >= 8'd10) begin
            v = v - 8'd10;
        end
        return v[3:0];
    endfunction

endpackage

>>> src/utf8dp_digit_lookup.sv
// Range match of a completed multi-byte character against the digit table.
module utf8dp_digit_lookup
    import utf8dp_pkg::*;
(
    input  logic [1:0]  char_len,
    input  logic [23:0] held,
    input  logic [7:0]  tail_byte,
    output digit_hit_t  result
);

    always_comb
    begin
        logic       m;
        logic [3:0] d;
        result.hit   = 1'b0;
        result.digit = 4'd0;
        for (int i = 0; i < RANGE_COUNT; i++) begin
            m = (DIGIT_RANGES[i].len_m1 == char_len) &&
                (DIGIT_RANGES[i].prefix == held) &&
                (tail_byte >= DIGIT_RANGES[i].lo) &&
                (tail_byte <= DIGIT_RANGES[i].hi);
            d = fold_digit(tail_byte - DIGIT_RANGES[i].lo);
            result.hit   = result.hit | m;
            result.digit = result.digit | (m ? d : 4'd0);
        end
    end

endmodule

>>> src/utf8_unicode_decimal_parser_top.sv
// Top level of the UTF-8 decimal integer parser.
//
//  channel  | handshake           | payload
//  ---------+---------------------+---------------------------------
//  input    | in_valid / in_ready | data_byte[7:0], has_byte, last
//  output   | out_valid/out_ready | parse_ok, value[31:0] signed
//
// One byte per cycle unless a last byte awaits the output: a byte enters the
// input register; decode, table match and multiply-by-ten update the parse state.
// A step marked last loads the result register and returns the state to reset.
// An output stall holds back only a last byte and the bytes behind it; others flow.
// Reset is asynchronous; in_ready is high from reset, so the first edge after
// release can take a byte.
module utf8_unicode_decimal_parser_top
    import utf8dp_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    data_byte,
    input  logic                          has_byte,
    input  logic                          last,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          parse_ok,
    output logic signed [VALUE_OUT_W-1:0] value
);

    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic                   in_has_reg;
    logic                   in_last_reg;

    logic [VALUE_WIDTH-1:0] acc_reg, acc_next;
    logic                   neg_reg, neg_next;
    logic                   failed_reg, failed_next;
    logic                   at_first_reg, at_first_next;
    logic [23:0]            held_reg, held_next;
    logic [1:0]             pending_reg, pending_next;
    logic [1:0]             char_len_reg, char_len_next;

    logic                          out_valid_reg;
    logic                          parse_ok_reg, parse_ok_next;
    logic signed [VALUE_OUT_W-1:0] value_reg, value_next;

    logic                   proc_fire;
    digit_hit_t             lookup;
    logic [2:0]             lead_len;
    logic                   mac_en;
    logic [3:0]             mac_digit;
    logic [VALUE_WIDTH-1:0] acc_mac;
    logic [VALUE_WIDTH-1:0] final_val;
    logic signed [VALUE_WIDTH-1:0] final_signed;
    logic                   ok;

    // A byte without a result never waits on the output side
    assign proc_fire = in_valid_reg && (!in_last_reg || !out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || proc_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (in_ready) begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            in_byte_reg <= data_byte;
            in_has_reg  <= has_byte;
            in_last_reg <= last;
        end
    end

    utf8dp_digit_lookup u_lookup (
        .char_len  (char_len_reg),
        .held      (held_reg),
        .tail_byte (in_byte_reg),
        .result    (lookup)
    );

    assign lead_len = lead_length(in_byte_reg);
    assign acc_mac  = (acc_reg << 3) + (acc_reg << 1) + VALUE_WIDTH'(mac_digit);

    always_comb
    begin
        acc_next      = acc_reg;
        neg_next      = neg_reg;
        failed_next   = failed_reg;
        at_first_next = at_first_reg;
        held_next     = held_reg;
        pending_next  = pending_reg;
        char_len_next = char_len_reg;
        mac_en        = 1'b0;
        mac_digit     = 4'd0;

        if (in_has_reg) begin
            if (!failed_reg) begin
                if (at_first_reg && (in_byte_reg == CHAR_MINUS || in_byte_reg == CHAR_PLUS)) begin
                    neg_next = (in_byte_reg == CHAR_MINUS);
                end else if (pending_reg == 2'd0) begin
                    if (lead_len == 3'd0) begin
                        failed_next = 1'b1;
                    end else if (lead_len == 3'd1) begin
                        mac_en    = 1'b1;
                        mac_digit = 4'(in_byte_reg - CHAR_ZERO);
                    end else begin
                        held_next     = {16'h0000, in_byte_reg};
                        char_len_next = 2'(lead_len - 3'd1);
                        pending_next  = 2'(lead_len - 3'd1);
                    end
                end else begin
                    pending_next = pending_reg - 2'd1;
                    if (pending_reg == 2'd1) begin
                        if (lookup.hit) begin
                            mac_en    = 1'b1;
                            mac_digit = lookup.digit;
                        end else begin
                            failed_next = 1'b1;
                        end
                        held_next     = 24'h000000;
                        char_len_next = 2'd0;
                    end else begin
                        held_next = {held_reg[15:0], in_byte_reg};
                    end
                end
            end
            at_first_next = 1'b0;
        end

        if (mac_en) begin
            acc_next = acc_mac;
        end

        ok              = !failed_next && (pending_next == 2'd0);
        final_val       = neg_next ? (~acc_next + VALUE_WIDTH'(1)) : acc_next;
        final_signed    = $signed(final_val);
        parse_ok_next   = ok;
        value_next      = ok ? VALUE_OUT_W'(final_signed) : '0;

        // End of string: back to the reset state for the next one
        if (in_last_reg) begin
            acc_next      = '0;
            neg_next      = 1'b0;
            failed_next   = 1'b0;
            at_first_next = 1'b1;
            held_next     = 24'h000000;
            pending_next  = 2'd0;
            char_len_next = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            acc_reg      <= '0;
            neg_reg      <= 1'b0;
            failed_reg   <= 1'b0;
            at_first_reg <= 1'b1;
            held_reg     <= 24'h000000;
            pending_reg  <= 2'd0;
            char_len_reg <= 2'd0;
        end else if (proc_fire) begin
            acc_reg      <= acc_next;
            neg_reg      <= neg_next;
            failed_reg   <= failed_next;
            at_first_reg <= at_first_next;
            held_reg     <= held_next;
            pending_reg  <= pending_next;
            char_len_reg <= char_len_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (proc_fire && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_fire && in_last_reg) begin
            parse_ok_reg <= parse_ok_next;
            value_reg    <= value_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign parse_ok  = parse_ok_reg;
    assign value     = value_reg;

    a_pending_has_len: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd0 |-> pending_reg <= char_len_reg)
        else $error("bytes pending exceed the character length");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !parse_ok_reg |-> value_reg == '0)
        else $error("failed parse carries a nonzero value");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        proc_fire && in_last_reg |=> at_first_reg && acc_reg == '0 && !failed_reg)
        else $error("state not cleared after end of string");

    a_fail_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        failed_reg && !(proc_fire && in_last_reg) |=> failed_reg)
        else $error("failure flag dropped before end of string");

    a_result_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(proc_fire && in_last_reg))
        else $error("result appeared without an end-of-string byte");

endmodule
